/* rtl/velocity_magnitude_heatmap_pixel_core_macros.svh */
// Assertion helpers for the velocity magnitude heat-map pixel core.
// Used inside modules that have clk and rst_n in scope.
`ifndef VELOCITY_MAGNITUDE_HEATMAP_PIXEL_CORE_MACROS_SVH
`define VELOCITY_MAGNITUDE_HEATMAP_PIXEL_CORE_MACROS_SVH

// checked only outside reset
`define VMHP_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) expr) \
    else $error(msg);

// checked on every edge, reset included
`define VMHP_ASSERT_RST(name, expr, msg) \
  name: assert property (@(posedge clk) expr) \
    else $error(msg);

`endif

/* rtl/vmhp_pkg.sv */
// Shared widths, constants and payload types of the velocity heat-map pixel core.
// No dependencies.
`default_nettype none

package vmhp_pkg;

  localparam int VEL_BITS   = 16;   // signed Q1.15 velocity samples
  localparam int FRAC_BITS  = 8;    // unsigned Q0.8 pixel offsets
  localparam int LID_BITS   = 16;   // unsigned Q8.8 scale register
  localparam int COLOR_BITS = 8;

  localparam logic [LID_BITS-1:0]   LID_RESET = LID_BITS'(2560);
  localparam logic [COLOR_BITS-1:0] COLOR_MAX = '1;

  // square-root steps resolved per pipeline stage
  localparam int SQRT_STEPS = 4;

  typedef struct packed {
    logic signed [VEL_BITS-1:0] vx_corner_00;
    logic signed [VEL_BITS-1:0] vx_corner_10;
    logic signed [VEL_BITS-1:0] vx_corner_01;
    logic signed [VEL_BITS-1:0] vx_corner_11;
    logic signed [VEL_BITS-1:0] vy_corner_00;
    logic signed [VEL_BITS-1:0] vy_corner_10;
    logic signed [VEL_BITS-1:0] vy_corner_01;
    logic signed [VEL_BITS-1:0] vy_corner_11;
    logic [FRAC_BITS-1:0]       frac_x;
    logic [FRAC_BITS-1:0]       frac_y;
  } vmhp_in_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } vmhp_out_t;

endpackage

`default_nettype wire

/* rtl/velocity_magnitude_heatmap_pixel_core.sv */
// Velocity magnitude heat-map pixel: bilinear interpolation, magnitude, color map.
// Depends on vmhp_pkg and velocity_magnitude_heatmap_pixel_core_macros.svh.
//
// Usage
//   in_*  : one pixel request per accepted cycle (in_valid high, in_stall low):
//           corner velocities of both components and the fractional offsets.
//   out_* : one RGB result per pixel, in request order (out_valid high,
//           out_stall low moves it).
//   cfg_* : writes inverse_lid_speed (Q8.8); cfg_ready is always high. Write it
//           only while no pixel is in flight.
// Timing
//   One pixel per cycle sustained while out_stall stays low. 12 register stages at the
//   default widths: two lerp stages, squares, sum, VEL_BITS/SQRT_STEPS (rounded up)
//   square-root stages, rounding, scale multiply, color select, output register.
// Stall
//   The pipeline is parted from the output by a one-entry skid buffer; it keeps
//   taking requests while a result waits, and in_stall rises only once the skid
//   entry is occupied. Nothing is dropped or repeated.
// Reset
//   Synchronous rst_n clears all valid bits and loads inverse_lid_speed = 10.0.
`default_nettype none
`include "velocity_magnitude_heatmap_pixel_core_macros.svh"

module velocity_magnitude_heatmap_pixel_core (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  vmhp_pkg::vmhp_in_t                   in_data,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output vmhp_pkg::vmhp_out_t                  out_data,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [vmhp_pkg::LID_BITS-1:0]        cfg_data
);

  localparam int V   = vmhp_pkg::VEL_BITS;
  localparam int F   = vmhp_pkg::FRAC_BITS;
  localparam int L   = vmhp_pkg::LID_BITS;
  localparam int C   = vmhp_pkg::COLOR_BITS;
  localparam int SQS = vmhp_pkg::SQRT_STEPS;
  localparam int NSQ = (V + SQS - 1) / SQS;
  localparam int LW  = V + F + 2;              // lerp accumulator width
  localparam int PW  = V + L;                  // scaled product width
  localparam logic [LW-1:0] LERP_HALF = LW'(1) << (F - 1);
  localparam logic [LW-1:0] LERP_ONE  = LW'(1) << F;
  localparam logic [PW-1:0] ONE       = PW'(1) << (V + 7);
  localparam logic [PW-1:0] HALF      = ONE >> 1;

  // a*(1-f) + b*f with round to nearest, ties up
  function automatic logic signed [V-1:0] lerp(input logic signed [V-1:0] a,
                                               input logic signed [V-1:0] b,
                                               input logic [F-1:0] f);
    logic signed [LW-1:0] ae, be, wa, wb, t;
    ae = LW'(a);
    be = LW'(b);
    wb = signed'(LW'(f));
    wa = signed'(LERP_ONE) - wb;
    t  = ae * wa + be * wb + signed'(LERP_HALF);
    return t[F+V-1:F];
  endfunction

  // configuration
  logic [L-1:0] ils_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ils_r <= vmhp_pkg::LID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ils_r <= cfg_data;
    end
  end

  // pipeline advance: held only while the skid entry is occupied
  logic en;
  logic skid_v_r;
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // stage 1: lerp along x on both rows
  logic                s1_v_r;
  logic signed [V-1:0] vx0_r, vx1_r, vy0_r, vy1_r;
  logic [F-1:0]        fy_r;

  // stage 2: lerp along y
  logic                s2_v_r;
  logic signed [V-1:0] vx_r, vy_r;

  // stage 3: squares
  logic                s3_v_r;
  logic [2*V-1:0]      sqx_r, sqy_r;
  logic [V-1:0]        ax, ay;

  // stage 4: sum of squares
  logic                s4_v_r;
  logic [2*V-1:0]      sum_r;

  always_comb begin
    ax = vx_r[V-1] ? (~vx_r + V'(1)) : vx_r;
    ay = vy_r[V-1] ? (~vy_r + V'(1)) : vy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx0_r <= lerp(in_data.vx_corner_00, in_data.vx_corner_10, in_data.frac_x);
      vx1_r <= lerp(in_data.vx_corner_01, in_data.vx_corner_11, in_data.frac_x);
      vy0_r <= lerp(in_data.vy_corner_00, in_data.vy_corner_10, in_data.frac_x);
      vy1_r <= lerp(in_data.vy_corner_01, in_data.vy_corner_11, in_data.frac_x);
      fy_r  <= in_data.frac_y;
      vx_r  <= lerp(vx0_r, vx1_r, fy_r);
      vy_r  <= lerp(vy0_r, vy1_r, fy_r);
      sqx_r <= (2*V)'(ax) * (2*V)'(ax);
      sqy_r <= (2*V)'(ay) * (2*V)'(ay);
      sum_r <= sqx_r + sqy_r;
    end
  end

  // square root, SQS result bits per stage; remainder stays <= 2*root
  logic           sq_v_r    [NSQ];
  logic [V+1:0]   sq_rem_r  [NSQ];
  logic [V-1:0]   sq_root_r [NSQ];
  logic [2*V-1:0] sq_n_r    [NSQ];

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    logic           v_in;
    logic [V+1:0]   rem_in, rem_nxt;
    logic [V-1:0]   root_in, root_nxt;
    logic [2*V-1:0] n_in, n_nxt;

    if (j == 0) begin : g_first
      assign v_in    = s4_v_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = sum_r;
    end else begin : g_next
      assign v_in    = sq_v_r[j-1];
      assign rem_in  = sq_rem_r[j-1];
      assign root_in = sq_root_r[j-1];
      assign n_in    = sq_n_r[j-1];
    end

    always_comb begin : p_steps
      logic [V+3:0] cur, trial, diff;
      cur      = '0;
      trial    = '0;
      diff     = '0;
      rem_nxt  = rem_in;
      root_nxt = root_in;
      n_nxt    = n_in;
      for (int s = 0; s < SQS; s++) begin
        if (j * SQS + s < V) begin
          cur   = {rem_nxt, n_nxt[2*V-1 -: 2]};
          trial = {2'b00, root_nxt, 2'b01};
          diff  = cur - trial;
          if (cur >= trial) begin
            rem_nxt  = diff[V+1:0];
            root_nxt = {root_nxt[V-2:0], 1'b1};
          end else begin
            rem_nxt  = cur[V+1:0];
            root_nxt = {root_nxt[V-2:0], 1'b0};
          end
          n_nxt = n_nxt << 2;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j] <= 1'b0;
      end else if (en) begin
        sq_v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[j]  <= rem_nxt;
        sq_root_r[j] <= root_nxt;
        sq_n_r[j]    <= n_nxt;
      end
    end
  end

  // rounding, scale, color select
  logic           mag_v_r, prod_v_r, x_v_r;
  logic [V-1:0]   mag_r, mag_nxt;
  logic [PW-1:0]  p_r;
  logic [V+7:0]   psat;
  logic           lo_nxt, lo_r;
  logic [V+6:0]   x_nxt, x_r;

  // round up when the remainder exceeds the root
  assign mag_nxt = sq_root_r[NSQ-1]
                 + V'(sq_rem_r[NSQ-1] > (V+2)'(sq_root_r[NSQ-1]));

  always_comb begin
    psat   = (p_r > ONE) ? ONE[V+7:0] : p_r[V+7:0];
    lo_nxt = (PW'(psat) <= HALF);
    x_nxt  = lo_nxt ? psat[V+6:0] : (V+7)'(ONE[V+7:0] - psat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_v_r  <= 1'b0;
      prod_v_r <= 1'b0;
      x_v_r    <= 1'b0;
    end else if (en) begin
      mag_v_r  <= sq_v_r[NSQ-1];
      prod_v_r <= mag_v_r;
      x_v_r    <= prod_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      p_r   <= PW'(mag_r) * PW'(ils_r);
      lo_r  <= lo_nxt;
      x_r   <= x_nxt;
    end
  end

  // 510*x as shift and subtract, then round and map
  logic [PW-1:0]       ramp;
  logic [C-1:0]        lvl;
  vmhp_pkg::vmhp_out_t col_nxt;

  always_comb begin
    ramp = (PW'(x_r) << 9) - (PW'(x_r) << 1) + HALF;
    lvl  = ramp[V+7+C-1:V+7];
    if (lo_r) begin
      col_nxt.red   = lvl;
      col_nxt.green = lvl;
      col_nxt.blue  = vmhp_pkg::COLOR_MAX - lvl;
    end else begin
      col_nxt.red   = vmhp_pkg::COLOR_MAX;
      col_nxt.green = lvl;
      col_nxt.blue  = '0;
    end
  end

  // output register with one skid entry
  logic                out_v_r, out_ld, inc_v;
  vmhp_pkg::vmhp_out_t out_data_r, skid_data_r;

  assign out_ld = !out_v_r || !out_stall;
  assign inc_v  = x_v_r && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_ld) begin
      out_v_r  <= skid_v_r || inc_v;
      skid_v_r <= 1'b0;
    end else if (inc_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_data_r <= skid_v_r ? skid_data_r : col_nxt;
    end
    if (!out_ld && inc_v) begin
      skid_data_r <= col_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  `VMHP_ASSERT(a_leaving_item_lands, inc_v |=> out_v_r, "item leaving pipeline was lost")
  `VMHP_ASSERT(a_skid_fill_on_stall, !skid_v_r ##1 skid_v_r |-> $past(out_v_r && out_stall), "skid filled without stall")
  `VMHP_ASSERT(a_red_blue_sum, out_v_r |-> (C+1)'(out_data_r.red) + (C+1)'(out_data_r.blue) == (C+1)'(vmhp_pkg::COLOR_MAX), "red plus blue off full scale")
  `VMHP_ASSERT(a_green_le_red, out_v_r |-> out_data_r.green <= out_data_r.red, "green above red")
  `VMHP_ASSERT_RST(a_reset_clears, !rst_n |=> !out_v_r && !skid_v_r, "reset left a result pending")

endmodule

`default_nettype wire

/* bench/velocity_magnitude_heatmap_pixel_core_test.sv */
// Testbench for the velocity magnitude heat-map pixel core: interpolation, magnitude,
// scale and color map checked against an in-bench predictor, with random stalls.
// Depends on vmhp_pkg and velocity_magnitude_heatmap_pixel_core.
module velocity_magnitude_heatmap_pixel_core_test;
  import vmhp_pkg::*;

  localparam int PIPE_LATENCY   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PERCENT   = 33;
  localparam int PHASE_PIXELS   = 305;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  vmhp_in_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  vmhp_out_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LID_BITS-1:0] cfg_data  = '0;

  velocity_magnitude_heatmap_pixel_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and bookkeeping
  logic [LID_BITS-1:0] lid_scale = LID_RESET;
  vmhp_out_t           pending_colors[$];
  bit                  no_idle = 1'b0;
  int                  pixels_sent;
  int                  colors_checked;
  int                  scale_writes;
  int                  mismatches;
  int                  quiet_cycles;

  task automatic flag_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    mismatches++;
  endtask

  // (a*(S-f) + b*f)/S, nearest with ties upward
  function automatic longint lerp_q(longint a, longint b, logic [FRAC_BITS-1:0] f);
    longint w;
    w = longint'(f);
    return (a * ((64'sd1 <<< FRAC_BITS) - w) + b * w + (64'sd1 <<< (FRAC_BITS - 1)))
           >>> FRAC_BITS;
  endfunction

  function automatic longint unsigned root_nearest(longint unsigned n);
    longint unsigned root, step;
    root = 0;
    step = 64'd1 << 62;
    while (step > n) step >>= 2;
    while (step != 0) begin
      if (n >= root + step) begin
        n -= root + step;
        root = (root >> 1) + step;
      end else begin
        root >>= 1;
      end
      step >>= 2;
    end
    if (n > root) root++;
    return root;
  endfunction

  function automatic vmhp_out_t predict_color(vmhp_in_t px, logic [LID_BITS-1:0] scale);
    longint          vx0, vx1, vy0, vy1, vx, vy;
    longint unsigned ax, ay, mag, p, full, shade;
    vmhp_out_t       c;
    full = 64'd1 << (VEL_BITS + 7);
    vx0 = lerp_q(px.vx_corner_00, px.vx_corner_10, px.frac_x);
    vx1 = lerp_q(px.vx_corner_01, px.vx_corner_11, px.frac_x);
    vy0 = lerp_q(px.vy_corner_00, px.vy_corner_10, px.frac_x);
    vy1 = lerp_q(px.vy_corner_01, px.vy_corner_11, px.frac_x);
    vx  = lerp_q(vx0, vx1, px.frac_y);
    vy  = lerp_q(vy0, vy1, px.frac_y);
    ax  = (vx < 0) ? -vx : vx;
    ay  = (vy < 0) ? -vy : vy;
    mag = root_nearest(ax * ax + ay * ay);
    p   = mag * longint'(scale);
    if (p > full) p = full;
    if (p <= (full >> 1)) begin
      shade   = (510 * p + (full >> 1)) >> (VEL_BITS + 7);
      c.red   = shade[COLOR_BITS-1:0];
      c.green = shade[COLOR_BITS-1:0];
      c.blue  = COLOR_MAX - shade[COLOR_BITS-1:0];
    end else begin
      shade   = (510 * (full - p) + (full >> 1)) >> (VEL_BITS + 7);
      c.red   = COLOR_MAX;
      c.green = shade[COLOR_BITS-1:0];
      c.blue  = '0;
    end
    return c;
  endfunction

  function automatic vmhp_in_t corners(int x00, int x10, int x01, int x11,
                                       int y00, int y10, int y01, int y11,
                                       int fx, int fy);
    vmhp_in_t px;
    px.vx_corner_00 = x00[VEL_BITS-1:0];
    px.vx_corner_10 = x10[VEL_BITS-1:0];
    px.vx_corner_01 = x01[VEL_BITS-1:0];
    px.vx_corner_11 = x11[VEL_BITS-1:0];
    px.vy_corner_00 = y00[VEL_BITS-1:0];
    px.vy_corner_10 = y10[VEL_BITS-1:0];
    px.vy_corner_01 = y01[VEL_BITS-1:0];
    px.vy_corner_11 = y11[VEL_BITS-1:0];
    px.frac_x       = fx[FRAC_BITS-1:0];
    px.frac_y       = fy[FRAC_BITS-1:0];
    return px;
  endfunction

  // span picks the magnitude range so every color band gets hit; top span is raw bits
  function automatic logic signed [VEL_BITS-1:0] rand_velocity(int span);
    int v;
    if (span >= VEL_BITS - 1) return VEL_BITS'($urandom());
    v = int'($urandom_range((2 << span) - 1)) - (1 << span);
    return v[VEL_BITS-1:0];
  endfunction

  function automatic logic [FRAC_BITS-1:0] rand_fraction();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return FRAC_BITS'($urandom());
    endcase
  endfunction

  function automatic vmhp_in_t rand_pixel();
    vmhp_in_t px;
    int       span;
    span = $urandom_range(VEL_BITS - 1);
    px.vx_corner_00 = rand_velocity(span);
    px.vx_corner_10 = rand_velocity(span);
    px.vx_corner_01 = rand_velocity(span);
    px.vx_corner_11 = rand_velocity(span);
    px.vy_corner_00 = rand_velocity(span);
    px.vy_corner_10 = rand_velocity(span);
    px.vy_corner_01 = rand_velocity(span);
    px.vy_corner_11 = rand_velocity(span);
    px.frac_x       = rand_fraction();
    px.frac_y       = rand_fraction();
    return px;
  endfunction

  // valid stays high across back-to-back requests; idle gaps and settle() lower it
  task automatic send_pixel(input vmhp_in_t px);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    pending_colors.push_back(predict_color(px, lid_scale));
    pixels_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_lid_speed(input logic [LID_BITS-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    lid_scale = value;
    scale_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_scale();
    send_pixel(corners(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(corners(32767, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(corners(-32768, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // fraction zero: lower left corner passes through untouched
    send_pixel(corners(100, 9000, -9000, 5, -77, 3000, 3000, -3000, 0, 0));
    send_pixel(corners(1, 1, 1, 1, 0, 0, 0, 0, 200, 37));
    send_pixel(corners(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 255, 255));
    send_pixel(corners(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 128, 128));
    send_pixel(corners(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                       255, 1));
  endtask

  // at unity scale the half-way point and full scale are exact magnitudes
  task automatic test_color_threshold();
    write_lid_speed(LID_BITS'(256));
    send_pixel(corners(16384, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(corners(16385, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(corners(0, 0, 0, 0, -32768, 0, 0, 0, 0, 0));
    send_pixel(corners(32767, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(corners(8192, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(corners(3000, 0, 0, 0, 4000, 0, 0, 0, 0, 0));
  endtask

  task automatic test_scale_extremes();
    write_lid_speed('0);
    send_pixel(corners(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 9, 250));
    send_pixel(rand_pixel());
    // full scale makes one LSB of magnitude visible: rounding ties show here
    write_lid_speed('1);
    send_pixel(corners(0, 1, 0, 1, 0, 0, 0, 0, 128, 0));
    send_pixel(corners(0, -1, 0, -1, 0, 0, 0, 0, 128, 0));
    send_pixel(corners(1, 1, 1, 1, 1, 1, 1, 1, 0, 0));
    send_pixel(corners(1, 0, 0, 0, 2, 0, 0, 0, 0, 0));
    write_lid_speed(LID_BITS'(1));
    send_pixel(corners(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0));
  endtask

  task automatic test_random_pixels();
    logic [LID_BITS-1:0] scales[6];
    scales = '{LID_RESET, LID_BITS'(256), '1, LID_BITS'(1),
               LID_BITS'($urandom()), LID_BITS'($urandom())};
    foreach (scales[i]) begin
      write_lid_speed(scales[i]);
      no_idle = (i == 1);
      repeat (PHASE_PIXELS) send_pixel(rand_pixel());
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
  end

  always @(posedge clk) begin
    vmhp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_colors.size() == 0) begin
        flag_mismatch($sformatf("color %0d/%0d/%0d with no request pending",
                                out_data.red, out_data.green, out_data.blue));
      end else begin
        want = pending_colors.pop_front();
        colors_checked++;
        if (out_data.red !== want.red)
          flag_mismatch($sformatf("red %0d, want %0d", out_data.red, want.red));
        if (out_data.green !== want.green)
          flag_mismatch($sformatf("green %0d, want %0d", out_data.green, want.green));
        if (out_data.blue !== want.blue)
          flag_mismatch($sformatf("blue %0d, want %0d", out_data.blue, want.blue));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d pixels still in flight", pending_colors.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_scale();
    test_color_threshold();
    test_scale_extremes();
    test_random_pixels();
    settle();
    $display("%0d pixels sent, %0d colors compared, %0d scale writes incl. 0, 1 and max",
             pixels_sent, colors_checked, scale_writes);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl
rtl/vmhp_pkg.sv
rtl/velocity_magnitude_heatmap_pixel_core.sv
bench/velocity_magnitude_heatmap_pixel_core_test.sv
